### sv/dtb_pkg.sv
package dtb_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [59:0] FRAC_MAX   = 60'd999999999999999999;
  localparam logic [60:0] DEC_ONE    = 61'd1000000000000000000;
  localparam logic [59:0] DEC_HALF   = 60'd500000000000000000;
  localparam logic [63:0] TOP_BIT    = 64'h8000000000000000;
  localparam logic [63:0] ROUND_CAP  = 64'hFFFFFFFFFFFFF800;
  localparam logic [63:0] TEN_MANT   = 64'hA000000000000000;
  localparam logic [63:0] TENTH_MANT = 64'hCCCCCCCCCCCCCCCC;
  localparam logic signed [31:0] EXP_LIMIT = 32'sd646456992;
  localparam logic signed [31:0] EXACT_MAX = 32'sd18;

  typedef enum logic [2:0] {
    CLS_ZERO  = 3'd0,
    CLS_EXACT = 3'd1,
    CLS_OVF   = 3'd2,
    CLS_UNF   = 3'd3,
    CLS_NORM  = 3'd4
  } dtb_cls_t;

  typedef struct packed {
    logic [59:0]        frac;
    logic signed [31:0] dexp;
    dtb_cls_t           cls;
  } dtb_job_t;

  // 10^(18-idx): divisor that turns the scaled fraction into an integer
  function automatic logic [56:0] pow_ten_div(input logic [4:0] idx);
    logic [56:0] r;
    case (idx)
      5'd1:  r = 57'd100000000000000000;
      5'd2:  r = 57'd10000000000000000;
      5'd3:  r = 57'd1000000000000000;
      5'd4:  r = 57'd100000000000000;
      5'd5:  r = 57'd10000000000000;
      5'd6:  r = 57'd1000000000000;
      5'd7:  r = 57'd100000000000;
      5'd8:  r = 57'd10000000000;
      5'd9:  r = 57'd1000000000;
      5'd10: r = 57'd100000000;
      5'd11: r = 57'd10000000;
      5'd12: r = 57'd1000000;
      5'd13: r = 57'd100000;
      5'd14: r = 57'd10000;
      5'd15: r = 57'd1000;
      5'd16: r = 57'd100;
      5'd17: r = 57'd10;
      default: r = 57'd1;
    endcase
    return r;
  endfunction

endpackage

### sv/decimal_to_binary_float_convert.sv
// Decimal to binary floating-point converter.
// Input queue: push/full with dec_fraction (value scaled by 10^18) and
// dec_exponent; an item enters when push is high and full is low.
// Result queue: empty/pop with bin_fraction, bin_exponent (mantissa scaled
// by 2^64) and status (1 = overflow); the item is taken when pop is high and
// empty is low.
// A two-entry input queue lets the front take new items while the back
// engine works. One item is worked at a time:
//   zero, overflow, underflow: the result is set when the item is taken;
//   exact integers (exponent 1..18): a 60-step divide plus a
//   one-bit-per-cycle normalize;
//   other values: per exponent bit position a check, a square and a
//   normalize, with a multiply and a rounding step per set bit, then 64
//   fraction steps, a multiply and up to 64 normalize steps; with exponent
//   1..18 but no exact integer the 60-step divide comes first.
// The shared 32x32 multiplier (four partial products per 64x64 product) and
// the bit-serial fraction loop set how long an item takes.
// Synchronous reset empties both queues and returns the engine to idle.
// While pop is held low a finished result waits on the ports; the engine
// then holds its next result until the output register frees up.
module decimal_to_binary_float_convert import dtb_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [59:0]        dec_fraction,
  input  logic signed [31:0] dec_exponent,
  output logic               empty,
  input  logic               pop,
  output logic [63:0]        bin_fraction,
  output logic signed [31:0] bin_exponent,
  output logic               status
);

  dtb_job_t job;
  logic     job_valid, job_ready;

  dtb_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst, .push, .full, .dec_fraction, .dec_exponent,
    .job_valid, .job_ready, .job
  );

  dtb_back u_back (
    .clk, .rst, .job_valid, .job_ready, .job,
    .empty, .pop, .bin_fraction, .bin_exponent, .status
  );

endmodule

### sv/dtb_front.sv
module dtb_front import dtb_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [59:0]        dec_fraction,
  input  logic signed [31:0] dec_exponent,
  output logic               job_valid,
  input  logic               job_ready,
  output dtb_job_t           job
);

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  dtb_job_t          q [Depth];
  dtb_job_t          in_job;
  logic [PW-1:0]     wptr, rptr;
  logic [CW-1:0]     count;
  logic              do_push, do_pop;

  always_comb begin
    in_job.frac = (dec_fraction > FRAC_MAX) ? FRAC_MAX : dec_fraction;
    in_job.dexp = dec_exponent;
    if (in_job.frac == '0) begin
      in_job.cls = CLS_ZERO;
    end else if (dec_exponent >= 32'sd1 && dec_exponent <= EXACT_MAX) begin
      in_job.cls = CLS_EXACT;
    end else if (dec_exponent > EXP_LIMIT) begin
      in_job.cls = CLS_OVF;
    end else if (dec_exponent < -EXP_LIMIT) begin
      in_job.cls = CLS_UNF;
    end else begin
      in_job.cls = CLS_NORM;
    end
  end

  assign full      = (count == CW'(Depth));
  assign job_valid = (count != '0);
  assign job       = q[rptr];
  assign do_push   = push && !full;
  assign do_pop    = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wptr] <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(Depth - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(Depth - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/dtb_back.sv
module dtb_back import dtb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_ready,
  input  dtb_job_t           job,
  output logic               empty,
  input  logic               pop,
  output logic [63:0]        bin_fraction,
  output logic signed [31:0] bin_exponent,
  output logic               status
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'h0001,
    S_DIV    = 14'h0002,
    S_INORM  = 14'h0004,
    S_PSET   = 14'h0008,
    S_PCHK   = 14'h0010,
    S_PMUL   = 14'h0020,
    S_PNORM  = 14'h0040,
    S_SQ1    = 14'h0080,
    S_SQ2    = 14'h0100,
    S_SQ3    = 14'h0200,
    S_SQNORM = 14'h0400,
    S_FRAC   = 14'h0800,
    S_FMUL   = 14'h1000,
    S_FNORM  = 14'h2000
  } state_t;

  state_t state;
  logic   done;

  logic [59:0]        f;
  logic signed [31:0] dexp;
  logic [56:0]        dv, rem;
  logic [59:0]        quo;
  logic [5:0]         cnt;
  logic [63:0]        m1, m2, sq, pp;
  logic signed [39:0] pexp, se;
  logic [29:0]        mag;
  logic [127:0]       acc;
  logic [2:0]         mcnt;
  logic [59:0]        d;

  logic [63:0]        wf;
  logic [31:0]        wx;
  logic               ws;
  logic               ovalid;

  // fraction rounding is folded into the multiply entry
  logic [63:0] m2_rnd;
  assign m2_rnd = (d >= DEC_HALF && m2 < ROUND_CAP) ? m2 + 64'd1 : m2;

  // shared 32x32 multiplier, product registered
  logic [31:0]  ma, mb;
  logic [63:0]  xop, yop;
  logic [127:0] addend;
  logic [1:0]   kprev;

  always_comb begin
    xop = m1;
    yop = (state == S_FMUL) ? m2_rnd : sq;
    ma  = '0;
    mb  = '0;
    case (state)
      S_PMUL, S_FMUL: begin
        ma = mcnt[1] ? xop[63:32] : xop[31:0];
        mb = mcnt[0] ? yop[63:32] : yop[31:0];
      end
      S_SQ1: begin
        ma = sq[63:32];
        mb = sq[63:32];
      end
      S_SQ2: begin
        ma = sq[63:32];
        mb = sq[31:0];
      end
      default: ;
    endcase
  end

  assign kprev = 2'(mcnt - 3'd1);

  always_comb begin
    case (kprev)
      2'd0:    addend = {64'b0, pp};
      2'd3:    addend = {pp, 64'b0};
      default: addend = {32'b0, pp, 32'b0};
    endcase
  end

  // restoring division step
  logic [57:0] dt, dsub;
  logic        dge;
  logic [56:0] rem_n;
  logic [59:0] quo_n;
  assign dt    = {rem, quo[59]};
  assign dsub  = dt - {1'b0, dv};
  assign dge   = (dt >= {1'b0, dv});
  assign rem_n = dge ? dsub[56:0] : dt[56:0];
  assign quo_n = {quo[58:0], dge};

  // fraction bit step
  logic [60:0] fd, fsub;
  logic        fge;
  assign fd   = {d, 1'b0};
  assign fsub = fd - DEC_ONE;
  assign fge  = (fd >= DEC_ONE);

  // normalize-and-round after a power multiply
  logic [127:0]       pn_acc;
  logic signed [39:0] pn_e;
  logic [64:0]        pn_sum;
  assign pn_acc = acc[127] ? acc : {acc[126:0], 1'b0};
  assign pn_e   = pexp + se - (acc[127] ? 40'sd0 : 40'sd1);
  assign pn_sum = {1'b0, pn_acc[127:64]} + 65'(pn_acc[63]);

  logic [64:0] fn_sum;
  assign fn_sum = {1'b0, acc[127:64]} + 65'(acc[63]);

  logic [31:0] nege;
  assign nege = 32'(-dexp);

  assign job_ready    = (state == S_IDLE) && !done;
  assign empty        = !ovalid;

  always_ff @(posedge clk) begin
    pp <= 64'(ma) * 64'(mb);
    case (state)
      S_IDLE: begin
        if (job_valid && !done) begin
          f    <= job.frac;
          dexp <= job.dexp;
          wf   <= '0;
          wx   <= '0;
          ws   <= (job.cls == CLS_OVF);
          dv   <= pow_ten_div(job.dexp[4:0]);
          rem  <= '0;
          quo  <= job.frac;
          cnt  <= '0;
        end
      end
      S_DIV: begin
        rem <= rem_n;
        quo <= quo_n;
        cnt <= cnt + 1'b1;
        if (cnt == 6'd59) begin
          acc[63:0] <= {4'b0, quo_n};
          pexp      <= 40'sd64;
        end
      end
      S_INORM: begin
        if (acc[63]) begin
          wf <= acc[63:0];
          wx <= pexp[31:0];
        end else begin
          acc[63:0] <= {acc[62:0], 1'b0};
          pexp      <= pexp - 40'sd1;
        end
      end
      S_PSET: begin
        m1   <= TOP_BIT;
        pexp <= 40'sd1;
        if (dexp > 32'sd0) begin
          sq  <= TEN_MANT;
          se  <= 40'sd4;
          mag <= dexp[29:0];
        end else begin
          sq  <= TENTH_MANT;
          se  <= -40'sd3;
          mag <= nege[29:0];
        end
      end
      S_PCHK: begin
        acc  <= '0;
        mcnt <= '0;
        d    <= f;
        m2   <= '0;
        cnt  <= '0;
      end
      S_PMUL, S_FMUL: begin
        mcnt <= mcnt + 1'b1;
        if (mcnt != 3'd0) begin
          acc <= acc + addend;
        end
      end
      S_PNORM: begin
        if (pn_sum[64]) begin
          m1   <= TOP_BIT;
          pexp <= pn_e + 40'sd1;
        end else begin
          m1   <= pn_sum[63:0];
          pexp <= pn_e;
        end
      end
      S_SQ2: begin
        acc[63:0] <= pp;
      end
      S_SQ3: begin
        sq  <= acc[63:0] + {31'b0, pp[63:31]};
        se  <= se <<< 1;
        mag <= mag >> 1;
      end
      S_SQNORM: begin
        if (sq != '0 && !sq[63]) begin
          sq <= {sq[62:0], 1'b0};
          se <= se - 40'sd1;
        end
      end
      S_FRAC: begin
        if (cnt == 6'd63 && fge) begin
          d <= fsub[59:0];
        end else if (fge) begin
          d <= fsub[59:0];
        end else begin
          d <= fd[59:0];
        end
        m2  <= {m2[62:0], fge};
        cnt <= cnt + 1'b1;
        if (cnt == 6'd63) begin
          acc  <= '0;
          mcnt <= '0;
        end
      end
      S_FNORM: begin
        if (acc[127:64] == '0) begin
          wf <= '0;
          wx <= '0;
        end else if (acc[127]) begin
          if (fn_sum[64]) begin
            wf <= TOP_BIT;
            wx <= 32'(pexp + 40'sd1);
          end else begin
            wf <= fn_sum[63:0];
            wx <= pexp[31:0];
          end
        end else if (pexp <= -40'sd2147483648) begin
          wf <= '0;
          wx <= '0;
        end else begin
          acc  <= {acc[126:0], 1'b0};
          pexp <= pexp - 40'sd1;
        end
      end
      default: ;
    endcase
  end

  logic frac_last;
  assign frac_last = (state == S_FRAC) && (cnt == 6'd63);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (done && (!ovalid || pop)) begin
        ovalid <= 1'b1;
        done   <= 1'b0;
      end else if (pop && ovalid) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid && !done) begin
            case (job.cls)
              CLS_EXACT: state <= S_DIV;
              CLS_NORM:  state <= S_PSET;
              default:   done  <= 1'b1;
            endcase
          end
        end
        S_DIV: begin
          if (cnt == 6'd59) begin
            state <= (rem_n == '0) ? S_INORM : S_PSET;
          end
        end
        S_INORM: begin
          if (acc[63]) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_PSET: state <= S_PCHK;
        S_PCHK: begin
          if (mag == '0) begin
            state <= S_FRAC;
          end else if (mag[0]) begin
            state <= S_PMUL;
          end else begin
            state <= S_SQ1;
          end
        end
        S_PMUL: begin
          if (mcnt == 3'd4) begin
            state <= S_PNORM;
          end
        end
        S_PNORM: state <= S_SQ1;
        S_SQ1:   state <= S_SQ2;
        S_SQ2:   state <= S_SQ3;
        S_SQ3:   state <= S_SQNORM;
        S_SQNORM: begin
          if (!(sq != '0 && !sq[63])) begin
            state <= S_PCHK;
          end
        end
        S_FRAC: begin
          if (frac_last) begin
            state <= S_FMUL;
          end
        end
        S_FMUL: begin
          if (mcnt == 3'd4) begin
            state <= S_FNORM;
          end
        end
        S_FNORM: begin
          if (acc[127:64] == '0 || acc[127] || pexp <= -40'sd2147483648) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (done && (!ovalid || pop)) begin
      bin_fraction <= wf;
      bin_exponent <= wx;
      status       <= ws;
    end
  end

`ifndef ASSERT_OFF
  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    ovalid && status |-> bin_fraction == '0 && bin_exponent == '0)
    else $error("overflow result carries a nonzero value");
  a_norm: assert property (@(posedge clk) disable iff (rst)
    ovalid && bin_fraction != '0 |-> bin_fraction[63])
    else $error("result mantissa not normalized");
  a_take: assert property (@(posedge clk) disable iff (rst)
    job_valid && job_ready |=> state != S_IDLE || done)
    else $error("item taken but no work started");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import dtb_pkg::*;

  typedef struct {
    logic [63:0]        mant;
    logic signed [31:0] bexp;
    logic               ovf;
  } conv_result_t;

  // Exact 64x64 product split into high and low words.
  function automatic void mul_wide(input logic [63:0] x, input logic [63:0] y,
                                   output logic [63:0] hi, output logic [63:0] lo);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    hi = p[127:64];
    lo = p[63:0];
  endfunction

  function automatic void bump(inout logic [63:0] m, inout longint e, input logic bit_in);
    if (bit_in) begin
      m = m + 64'd1;
      if (m == 64'd0) begin
        m = TOP_BIT;
        e = e + 1;
      end
    end
  endfunction

  // 10^dexp as mantissa * 2^(e-64); squaring keeps a truncated top word
  function automatic void ten_power(input longint dexp, output logic [63:0] mant,
                                    output longint bexp);
    logic [63:0] acc, lo, sq, mag, stp, ah, al;
    longint e, se;
    acc = TOP_BIT;
    e = 1;
    stp = 64'd1;
    if (dexp > 0) begin
      sq = TEN_MANT; se = 4; mag = dexp;
    end else begin
      sq = TENTH_MANT; se = -3; mag = -dexp;
    end
    while (stp <= mag) begin
      if ((mag & stp) != 0) begin
        mul_wide(acc, sq, acc, lo);
        e = e + se;
        while (acc[63] == 1'b0) begin
          acc = {acc[62:0], lo[63]};
          lo = lo << 1;
          e = e - 1;
        end
        bump(acc, e, lo[63]);
      end
      ah = sq >> 32;
      al = sq & 64'hFFFFFFFF;
      sq = ah * ah + ((ah * al) >> 31);
      se = se * 2;
      stp = stp << 1;
      while (sq != 0 && sq[63] == 1'b0) begin
        sq = sq << 1;
        se = se - 1;
      end
    end
    mant = acc;
    bexp = e;
  endfunction

  function automatic logic [63:0] frac_bits(input logic [63:0] d);
    logic [63:0] b, r;
    b = TOP_BIT;
    r = 0;
    while (d != 0 && b != 0) begin
      d = d << 1;
      if (d >= 64'(DEC_ONE)) begin
        r = r | b;
        d = d - 64'(DEC_ONE);
      end
      b = b >> 1;
    end
    if (d >= 64'(DEC_HALF) && r < ROUND_CAP) r = r + 1;
    return r;
  endfunction

  function automatic conv_result_t convert(input logic [59:0] fin, input logic signed [31:0] ein);
    conv_result_t r;
    logic [63:0] f, dv, q, m1, m2, hi, lo;
    longint e, x;
    int top;
    r = '{64'd0, 32'sd0, 1'b0};
    f = 64'(fin);
    e = ein;
    if (f > 64'(FRAC_MAX)) f = 64'(FRAC_MAX);
    if (f == 0) return r;
    if (e >= 1 && e <= 18) begin
      dv = 1;
      for (int i = 0; i < 18 - e; i++) dv = dv * 10;
      q = f / dv;
      if (q * dv == f) begin
        top = 63;
        while (top > 0 && q[top] == 1'b0) top--;
        r.mant = q << (63 - top);
        r.bexp = top + 1;
        return r;
      end
    end
    if (e > EXP_LIMIT) begin
      r.ovf = 1'b1;
      return r;
    end
    if (e < -longint'(EXP_LIMIT)) return r;
    ten_power(e, m1, x);
    m2 = frac_bits(f);
    mul_wide(m1, m2, hi, lo);
    while (hi != 0 && hi[63] == 1'b0) begin
      hi = {hi[62:0], lo[63]};
      lo = lo << 1;
      if (x <= -64'sd2147483648) return r;
      x = x - 1;
    end
    if (hi != 0) bump(hi, x, lo[63]);
    else x = 0;
    r.mant = hi;
    r.bexp = x[31:0];
    return r;
  endfunction

  class conv_scoreboard;
    conv_result_t pending[$];
    int errors = 0;

    function void note_input(logic [59:0] f, logic signed [31:0] e);
      pending.push_back(convert(f, e));
    endfunction

    function void check_result(logic [63:0] m, logic signed [31:0] e, logic s);
      conv_result_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h %0d %b", $time, m, e, s);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (m !== w.mant) begin
        $display("%0t: bin_fraction exp %h got %h", $time, w.mant, m);
        errors++;
      end
      if (e !== w.bexp) begin
        $display("%0t: bin_exponent exp %0d got %0d", $time, w.bexp, e);
        errors++;
      end
      if (s !== w.ovf) begin
        $display("%0t: status exp %b got %b", $time, w.ovf, s);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1, push = 0, pop = 0;
  logic full, empty, status;
  logic [59:0] dec_fraction = 0;
  logic signed [31:0] dec_exponent = 0;
  logic [63:0] bin_fraction;
  logic signed [31:0] bin_exponent;

  conv_scoreboard board = new();
  int send_idle = 0, recv_idle = 0;
  bit hold_recv = 0;
  int idle_cycles = 0;

  decimal_to_binary_float_convert dut (.*);

  initial forever #5 clk = ~clk;

  // result side
  always @(posedge clk) begin
    if (!rst && pop && !empty) board.check_result(bin_fraction, bin_exponent, status);
    if (rst) pop <= 1'b0;
    else pop <= !hold_recv && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && ((push && !full) || (pop && !empty))) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > 20000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // push stays high after an accepted item; the next idle cycle or drain drops it
  task automatic send(input logic [59:0] f, input logic signed [31:0] e);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    dec_fraction <= f;
    dec_exponent <= e;
    do @(posedge clk); while (full);
    board.note_input(f, e);
  endtask

  function automatic logic [59:0] rand_frac();
    logic [63:0] v;
    case ($urandom_range(5))
      0: v = {$urandom, $urandom} & 64'h0FFF_FFFF_FFFF_FFFF;
      1: v = 64'(FRAC_MAX) - $urandom_range(3);
      2: v = $urandom_range(1000);
      3: begin
        v = $urandom_range(999999);
        for (int i = 0; i < $urandom_range(12); i++) v = v * 10;
      end
      default: v = {$urandom, $urandom} % 64'd1000000000000000000;
    endcase
    return v[59:0];
  endfunction

  function automatic logic signed [31:0] rand_exp();
    case ($urandom_range(6))
      0: return $urandom;
      1: return EXP_LIMIT + $signed($urandom_range(4)) - 2;
      2: return -EXP_LIMIT + $signed($urandom_range(4)) - 2;
      3: return $signed($urandom_range(40)) - 20;
      4: return $signed($urandom_range(1000)) - 500;
      default: return $signed($urandom_range(2 * EXP_LIMIT)) - EXP_LIMIT;
    endcase
  endfunction

  task automatic drain();
    push <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed corners
    send(0, 5);
    send(60'hFFF_FFFF_FFFF_FFFF, 0);
    send(FRAC_MAX, 18);
    send(60'd100000000000000000, 1);
    send(60'd120000000000000000, 3);
    send(60'd123400000000000000, 2);
    send(60'd1, 18);
    send(60'd5, 17);
    send(60'd1, 1);
    send(60'd500000000000000000, 0);
    send(FRAC_MAX, EXP_LIMIT);
    send(FRAC_MAX, EXP_LIMIT + 1);
    send(60'd1, -EXP_LIMIT);
    send(60'd1, -EXP_LIMIT - 1);
    send(60'd1, 32'sh7FFFFFFF);
    send(60'd1, 32'sh80000000);
    send(60'd314159265358979323, -1);
    send(60'd999999999999999000, 19);
    send(60'd1, -30);
    send(60'd1, 0);
    drain();
    // receiver holds off while items keep coming
    hold_recv = 1;
    fork
      begin repeat (400) @(posedge clk); hold_recv = 0; end
      begin
        repeat (8) send(rand_frac(), rand_exp());
        push <= 1'b0;
      end
    join
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 32 : (ph == 1) ? 83 : 0;
      recv_idle = (ph == 0) ? 83 : (ph == 1) ? 32 : 0;
      repeat (430) send(rand_frac(), rand_exp());
    end
    drain();
    repeat (300) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
